@@ design/e2q_pkg.sv @@
// Package: shared types, constants and the CORDIC angle table.
package e2q_pkg;

  localparam int AngW   = 15;
  localparam int QW     = 16;
  localparam int CW     = 34;    // CORDIC x/y/z width, Q.30 plus headroom
  localparam int TrigW  = 27;    // Q.24 cosine/sine
  localparam int TabLen = 24;
  localparam logic signed [CW-1:0] AngHalfPi  = 34'sd1686629713;
  localparam logic signed [CW-1:0] AngPi      = 34'sd3373259426;
  localparam logic signed [CW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [QW-1:0] OutMax     = 16'sd32767;

  typedef struct packed {
    logic signed [TrigW-1:0] c;
    logic signed [TrigW-1:0] s;
  } trig_t;

  function automatic logic signed [CW-1:0] atan_tab(input logic [4:0] i);
    logic signed [CW-1:0] r;
    case (i)
      5'd0:  r = 34'sd843314856;
      5'd1:  r = 34'sd497837829;
      5'd2:  r = 34'sd263043836;
      5'd3:  r = 34'sd133525158;
      5'd4:  r = 34'sd67021686;
      5'd5:  r = 34'sd33543515;
      5'd6:  r = 34'sd16775850;
      5'd7:  r = 34'sd8388437;
      5'd8:  r = 34'sd4194282;
      5'd9:  r = 34'sd2097149;
      5'd10: r = 34'sd1048575;
      5'd11: r = 34'sd524287;
      5'd12: r = 34'sd262143;
      5'd13: r = 34'sd131071;
      5'd14: r = 34'sd65535;
      5'd15: r = 34'sd32767;
      5'd16: r = 34'sd16383;
      5'd17: r = 34'sd8191;
      5'd18: r = 34'sd4095;
      5'd19: r = 34'sd2047;
      5'd20: r = 34'sd1023;
      5'd21: r = 34'sd511;
      5'd22: r = 34'sd255;
      5'd23: r = 34'sd127;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ design/e2q_cordic.sv @@
// Pipelined half-angle CORDIC lane: one angle in, cosine and sine out.
module e2q_cordic #(
  parameter int Stages = 16
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic signed [e2q_pkg::AngW-1:0]       angle_i,
  output e2q_pkg::trig_t                        trig_o
);
  localparam int CW = e2q_pkg::CW;

  logic signed [CW-1:0] x_q [Stages+1];
  logic signed [CW-1:0] y_q [Stages+1];
  logic signed [CW-1:0] z_q [Stages+1];
  logic                 flip_q [Stages+1];
  logic signed [CW-1:0] z0;
  logic signed [CW-1:0] xf, yf;

  always_comb begin
    z0 = CW'(angle_i) <<< 17;
  end

  // fold half angle beyond +-pi/2
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= e2q_pkg::CordicGain;
      y_q[0] <= '0;
      if (z0 > e2q_pkg::AngHalfPi) begin
        z_q[0] <= z0 - e2q_pkg::AngPi;
        flip_q[0] <= 1'b1;
      end else if (z0 < -e2q_pkg::AngHalfPi) begin
        z_q[0] <= z0 + e2q_pkg::AngPi;
        flip_q[0] <= 1'b1;
      end else begin
        z_q[0] <= z0;
        flip_q[0] <= 1'b0;
      end
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][CW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - e2q_pkg::atan_tab(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + e2q_pkg::atan_tab(5'(i));
        end
      end
    end
  end

  always_comb begin
    xf = flip_q[Stages] ? -x_q[Stages] : x_q[Stages];
    yf = flip_q[Stages] ? -y_q[Stages] : y_q[Stages];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_o.c <= e2q_pkg::TrigW'((xf + CW'(32)) >>> 6);
      trig_o.s <= e2q_pkg::TrigW'((yf + CW'(32)) >>> 6);
    end
  end
endmodule

@@ design/e2q_merge.sv @@
// Merge stage: triple products, sums, rounding and saturation.
module e2q_merge (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  e2q_pkg::trig_t                  p_i,
  input  e2q_pkg::trig_t                  r_i,
  input  e2q_pkg::trig_t                  y_i,
  output logic signed [e2q_pkg::QW-1:0]   w_o,
  output logic signed [e2q_pkg::QW-1:0]   x_o,
  output logic signed [e2q_pkg::QW-1:0]   y_o,
  output logic signed [e2q_pkg::QW-1:0]   z_o
);
  localparam int TW = e2q_pkg::TrigW;
  localparam int PW = 2 * TW;

  // stage 1: pair products yaw x roll, rounded to Q.24
  logic signed [TW-1:0] cycr_q, sysr_q, cysr_q, sycr_q;
  logic signed [TW-1:0] cp_q, sp_q;
  logic signed [PW-1:0] p_cycr, p_sysr, p_cysr, p_sycr;

  always_comb begin
    p_cycr = PW'(y_i.c) * PW'(r_i.c);
    p_sysr = PW'(y_i.s) * PW'(r_i.s);
    p_cysr = PW'(y_i.c) * PW'(r_i.s);
    p_sycr = PW'(y_i.s) * PW'(r_i.c);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cycr_q <= TW'((p_cycr + (PW'(1) <<< 23)) >>> 24);
      sysr_q <= TW'((p_sysr + (PW'(1) <<< 23)) >>> 24);
      cysr_q <= TW'((p_cysr + (PW'(1) <<< 23)) >>> 24);
      sycr_q <= TW'((p_sycr + (PW'(1) <<< 23)) >>> 24);
      cp_q   <= p_i.c;
      sp_q   <= p_i.s;
    end
  end

  // stage 2: products with the pitch factor
  logic signed [PW-1:0] t_q [8];
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0] <= PW'(cycr_q) * PW'(cp_q);
      t_q[1] <= PW'(sysr_q) * PW'(sp_q);
      t_q[2] <= PW'(cysr_q) * PW'(cp_q);
      t_q[3] <= PW'(sycr_q) * PW'(sp_q);
      t_q[4] <= PW'(cycr_q) * PW'(sp_q);
      t_q[5] <= PW'(sysr_q) * PW'(cp_q);
      t_q[6] <= PW'(sycr_q) * PW'(cp_q);
      t_q[7] <= PW'(cysr_q) * PW'(sp_q);
    end
  end

  function automatic logic signed [e2q_pkg::QW-1:0] fin(input logic signed [PW:0] v);
    logic signed [PW:0] r;
    r = (v + ((PW+1)'(1) <<< 32)) >>> 33;
    if (r > (PW+1)'(e2q_pkg::OutMax)) return e2q_pkg::OutMax;
    if (r < -(PW+1)'(e2q_pkg::OutMax)) return -e2q_pkg::OutMax;
    return r[e2q_pkg::QW-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      w_o <= fin((PW+1)'(t_q[0]) + (PW+1)'(t_q[1]));
      x_o <= fin((PW+1)'(t_q[2]) - (PW+1)'(t_q[3]));
      y_o <= fin((PW+1)'(t_q[4]) + (PW+1)'(t_q[5]));
      z_o <= fin((PW+1)'(t_q[6]) - (PW+1)'(t_q[7]));
    end
  end
endmodule

@@ design/euler_to_quaternion_top.sv @@
// Top level: three CORDIC lanes, merge stage, stall-as-a-whole pipeline.
//  channel | signals                               | dir
//  in      | in_valid_i/in_ready_o, *_angle_i      | request in
//  out     | out_valid_o/out_ready_i, quat_*_o     | request out
// One request per cycle when out is not stalled.
// The whole pipeline advances together; a stalled output freezes it and in_ready_o
// drops only while the final stage holds a result not yet taken.
// Reset clears the valid bits only.
module euler_to_quaternion_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [e2q_pkg::AngW-1:0]    pitch_angle_i,
  input  logic signed [e2q_pkg::AngW-1:0]    roll_angle_i,
  input  logic signed [e2q_pkg::AngW-1:0]    yaw_angle_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [e2q_pkg::QW-1:0]      quat_w_o,
  output logic signed [e2q_pkg::QW-1:0]      quat_x_o,
  output logic signed [e2q_pkg::QW-1:0]      quat_y_o,
  output logic signed [e2q_pkg::QW-1:0]      quat_z_o
);
  localparam int Lat = CORDIC_STAGES + 5;

  logic [Lat-1:0] vld_q;
  logic en;
  e2q_pkg::trig_t tp, tr, ty;

  assign en = out_ready_i || !vld_q[Lat-1];
  assign in_ready_o = en;
  assign out_valid_o = vld_q[Lat-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], in_valid_i};
    end
  end

  e2q_cordic #(.Stages(CORDIC_STAGES)) u_lane_p (
    .clk_i(clk_i), .en_i(en), .angle_i(pitch_angle_i), .trig_o(tp));
  e2q_cordic #(.Stages(CORDIC_STAGES)) u_lane_r (
    .clk_i(clk_i), .en_i(en), .angle_i(roll_angle_i), .trig_o(tr));
  e2q_cordic #(.Stages(CORDIC_STAGES)) u_lane_y (
    .clk_i(clk_i), .en_i(en), .angle_i(yaw_angle_i), .trig_o(ty));

  e2q_merge u_merge (
    .clk_i(clk_i), .en_i(en), .p_i(tp), .r_i(tr), .y_i(ty),
    .w_o(quat_w_o), .x_o(quat_x_o), .y_o(quat_y_o), .z_o(quat_z_o));
endmodule

@@ design/e2q_checker.sv @@
// Port-level checker for the top level, with its bind.
module e2q_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic signed [e2q_pkg::QW-1:0] quat_w_o
);
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o) else $error("ready low with empty output");
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o) else $error("accept during stall");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(quat_w_o))
    else $error("output dropped");
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quat_w_o != -16'sd32768) else $error("saturation miss");
endmodule

bind euler_to_quaternion_top e2q_checker u_e2q_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .quat_w_o(quat_w_o));
